[src/c2p_pkg.sv]
// c2p_pkg: payload types, stage record, and fixed constants for cartesian_to_polar
// holds the arctangent table in units of 2^-32 turn used by the cordic steps
// no dependencies
package c2p_pkg;

   // field widths fixed by the interface
   localparam int COORD_BITS  = 16;
   localparam int ANGLE_BITS  = 16;
   // cordic datapath and angle accumulator widths
   localparam int CW          = 64;
   localparam int ACC_BITS    = 32;
   localparam int SCALE_SHIFT = 60 - COORD_BITS;
   // restoring square root: one result bit per step
   localparam int SQRT_STEPS  = COORD_BITS;
   localparam int SQ_BITS     = 2 * COORD_BITS;
   localparam logic [COORD_BITS-1:0] MAG_MAX = 16'd46341;

   // angle codes for points on an axis (origin uses the positive x code)
   localparam logic [1:0] QUAD_POS_X = 2'd0;
   localparam logic [1:0] QUAD_POS_Y = 2'd1;
   localparam logic [1:0] QUAD_NEG_X = 2'd2;
   localparam logic [1:0] QUAD_NEG_Y = 2'd3;

   // atan(2^-i) in 2^-32 turn
   localparam logic [ACC_BITS-1:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic [COORD_BITS-1:0] x_coord;
      logic [COORD_BITS-1:0] y_coord;
   } c2p_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] magnitude;
      logic [ANGLE_BITS-1:0] angle;
   } c2p_rsp_type;

   // one entry of the iteration pipeline
   typedef struct packed {
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic [ACC_BITS-1:0]  acc;
      logic [SQ_BITS-1:0]   rem;
      logic [SQ_BITS-1:0]   res;
      logic                 on_axis;
      logic [1:0]           quad;
   } c2p_stage_type;

endpackage

[src/cartesian_to_polar.sv]
// cartesian_to_polar: pipelined cordic vectoring angle and integer square root magnitude
// depends on c2p_pkg for payload types, stage record and the arctangent table
//
// throughput: one item per cycle while rsp_ready stays high, set by one cordic and one root step per pipeline stage
// each stage holds its item while the next one is full and cannot move on, so stalls lose nothing
// reset: synchronous, clears all valid bits; no clearing pass, ready right after reset
module cartesian_to_polar #(
   parameter int STAGES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  c2p_pkg::c2p_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output c2p_pkg::c2p_rsp_type rsp_data
);

   localparam int N = (STAGES > c2p_pkg::SQRT_STEPS) ? STAGES : c2p_pkg::SQRT_STEPS;
   localparam int CB = c2p_pkg::COORD_BITS;
   localparam int CW = c2p_pkg::CW;
   localparam int AB = c2p_pkg::ACC_BITS;
   localparam int SB = c2p_pkg::SQ_BITS;

   // input register stage
   logic                 a_valid_ff;
   c2p_pkg::c2p_req_type a_data_ff;
   logic                 a_rdy;

   // prep stage: squares, half-turn pre-rotation, axis codes
   logic                  b_valid_ff;
   logic [SB-1:0]         b_sqx_ff, b_sqy_ff, b_sqx_in, b_sqy_in;
   logic signed [CB:0]    b_xr_ff, b_yr_ff, b_xr_in, b_yr_in;
   logic [AB-1:0]         b_acc_ff, b_acc_in;
   logic                  b_axis_ff, b_axis_in;
   logic [1:0]            b_quad_ff, b_quad_in;
   logic                  b_rdy;

   // iteration pipeline
   logic [N:0]                pv_ff;
   c2p_pkg::c2p_stage_type    pd_ff [0:N];
   c2p_pkg::c2p_stage_type    pd_in [0:N];
   logic [N:0]                p_rdy;

   // output register
   logic                 rsp_valid_ff;
   c2p_pkg::c2p_rsp_type rsp_data_ff, rsp_data_in;
   logic                 out_rdy;

   // ready chain: a stage loads when empty or when its successor loads
   assign out_rdy   = !rsp_valid_ff || rsp_ready;
   assign p_rdy[N]  = !pv_ff[N] || out_rdy;
   for (genvar j = 0; j < N; j++) begin : g_rdy
      assign p_rdy[j] = !pv_ff[j] || p_rdy[j+1];
   end
   assign b_rdy     = !b_valid_ff || p_rdy[0];
   assign a_rdy     = !a_valid_ff || b_rdy;
   assign req_ready = a_rdy;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_rdy) begin
         a_valid_ff <= req_valid;
      end
      if (a_rdy) begin
         a_data_ff <= req_data;
      end
   end

   // prep logic
   logic signed [CB:0]  xe, ye;
   logic [CB-1:0]       ux, uy;
   logic                neg_x;
   always_comb begin
      xe    = {a_data_ff.x_coord[CB-1], a_data_ff.x_coord};
      ye    = {a_data_ff.y_coord[CB-1], a_data_ff.y_coord};
      ux    = a_data_ff.x_coord[CB-1] ? CB'(-a_data_ff.x_coord) : a_data_ff.x_coord;
      uy    = a_data_ff.y_coord[CB-1] ? CB'(-a_data_ff.y_coord) : a_data_ff.y_coord;
      neg_x = a_data_ff.x_coord[CB-1];
      b_sqx_in = SB'(ux) * SB'(ux);
      b_sqy_in = SB'(uy) * SB'(uy);
      b_xr_in  = neg_x ? -xe : xe;
      b_yr_in  = neg_x ? -ye : ye;
      b_acc_in = neg_x ? {1'b1, {(AB-1){1'b0}}} : '0;
      b_axis_in = (xe == '0) || (ye == '0);
      if (ye == '0) begin
         b_quad_in = (xe > 0 || xe == '0) ? c2p_pkg::QUAD_POS_X : c2p_pkg::QUAD_NEG_X;
      end else begin
         b_quad_in = (ye > 0) ? c2p_pkg::QUAD_POS_Y : c2p_pkg::QUAD_NEG_Y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_rdy) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_rdy) begin
         b_sqx_ff  <= b_sqx_in;
         b_sqy_ff  <= b_sqy_in;
         b_xr_ff   <= b_xr_in;
         b_yr_ff   <= b_yr_in;
         b_acc_ff  <= b_acc_in;
         b_axis_ff <= b_axis_in;
         b_quad_ff <= b_quad_in;
      end
   end

   // entry of the iteration pipeline: radicand sum and scaled coordinates
   always_comb begin
      pd_in[0].cx      = {{(CW-CB-1){b_xr_ff[CB]}}, b_xr_ff} <<< c2p_pkg::SCALE_SHIFT;
      pd_in[0].cy      = {{(CW-CB-1){b_yr_ff[CB]}}, b_yr_ff} <<< c2p_pkg::SCALE_SHIFT;
      pd_in[0].acc     = b_acc_ff;
      pd_in[0].rem     = b_sqx_ff + b_sqy_ff;
      pd_in[0].res     = '0;
      pd_in[0].on_axis = b_axis_ff;
      pd_in[0].quad    = b_quad_ff;
   end

   // one cordic rotation per stage below STAGES and one root bit per stage below SQRT_STEPS
   for (genvar j = 0; j < N; j++) begin : g_step
      localparam int SQ_SH = (j < c2p_pkg::SQRT_STEPS) ? 2 * (c2p_pkg::SQRT_STEPS - 1 - j) : 0;
      localparam logic [SB-1:0] SQ_BIT = SB'(1) << SQ_SH;
      logic signed [CW-1:0] dx, dy;
      logic [SB:0]          trial;
      always_comb begin
         pd_in[j+1] = pd_ff[j];
         dx    = pd_ff[j].cy >>> j;
         dy    = pd_ff[j].cx >>> j;
         trial = {1'b0, pd_ff[j].res} + {1'b0, SQ_BIT};
         if (j < STAGES) begin
            if (pd_ff[j].cy > 0) begin
               pd_in[j+1].cx  = pd_ff[j].cx + dx;
               pd_in[j+1].cy  = pd_ff[j].cy - dy;
               pd_in[j+1].acc = pd_ff[j].acc + c2p_pkg::ATAN_TURNS[j];
            end else begin
               pd_in[j+1].cx  = pd_ff[j].cx - dx;
               pd_in[j+1].cy  = pd_ff[j].cy + dy;
               pd_in[j+1].acc = pd_ff[j].acc - c2p_pkg::ATAN_TURNS[j];
            end
         end
         if (j < c2p_pkg::SQRT_STEPS) begin
            if ({1'b0, pd_ff[j].rem} >= trial) begin
               pd_in[j+1].rem = pd_ff[j].rem - trial[SB-1:0];
               pd_in[j+1].res = (pd_ff[j].res >> 1) + SQ_BIT;
            end else begin
               pd_in[j+1].res = pd_ff[j].res >> 1;
            end
         end
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      for (int k = 0; k <= N; k++) begin
         if (reset) begin
            pv_ff[k] <= 1'b0;
         end else if (p_rdy[k]) begin
            pv_ff[k] <= (k == 0) ? b_valid_ff : pv_ff[(k == 0) ? 0 : k - 1];
         end
         if (p_rdy[k]) begin
            pd_ff[k] <= pd_in[k];
         end
      end
   end

   // final rounding of root and angle
   logic [SB-1:0] mag_full;
   logic [AB-1:0] acc_sel, acc_rnd;
   always_comb begin
      mag_full = pd_ff[N].res + SB'(pd_ff[N].rem > pd_ff[N].res);
      acc_sel  = pd_ff[N].on_axis ? {pd_ff[N].quad, {(AB-2){1'b0}}} : pd_ff[N].acc;
      acc_rnd  = acc_sel + (AB'(1) << (AB - 1 - c2p_pkg::ANGLE_BITS));
      rsp_data_in.magnitude = mag_full[CB-1:0];
      rsp_data_in.angle     = acc_rnd[AB-1 -: c2p_pkg::ANGLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= pv_ff[N];
      end
      if (out_rdy) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // input side stalls only when the input register holds an item
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> a_valid_ff)
      else $error("req_ready low with empty input stage");

   // a finished item in the last stage moves on when the output can take it
   a_last_moves: assert property (@(posedge clock) disable iff (reset)
      pv_ff[N] && out_rdy |=> rsp_valid_ff)
      else $error("last stage item not delivered");

   // root remainder stays within 2 * root after the last step
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      pv_ff[N] |-> ({1'b0, pd_ff[N].rem} <= {pd_ff[N].res, 1'b0}))
      else $error("square root remainder out of range");

   // magnitude never exceeds the largest possible norm
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.magnitude <= c2p_pkg::MAG_MAX)
      else $error("magnitude out of range");
`endif

endmodule

[test/tb_cartesian_to_polar.sv]
// tb_cartesian_to_polar: self-checking testbench for the cartesian to polar converter
// depends on c2p_pkg for payload types and the arctangent table, and on cartesian_to_polar
// directed vectors, then random points; checked against exact values or a local model
`timescale 1ns / 1ps

module tb_cartesian_to_polar;

   localparam int STAGES       = 16;
   localparam int DRAIN_CYCLES = 64;
   localparam int RANDOM_ITEMS = 1550;
   localparam int TIMEOUT_NS   = 3_000_000;
   localparam int CB           = c2p_pkg::COORD_BITS;

   // exact angles on the axes
   localparam logic [c2p_pkg::ANGLE_BITS-1:0] ZERO_TURN     = 16'h0000;
   localparam logic [c2p_pkg::ANGLE_BITS-1:0] QUARTER_TURN  = 16'h4000;
   localparam logic [c2p_pkg::ANGLE_BITS-1:0] HALF_TURN     = 16'h8000;
   localparam logic [c2p_pkg::ANGLE_BITS-1:0] THREE_QUARTER = 16'hC000;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PERIODIC
   } rx_mode_type;

   typedef struct {
      c2p_pkg::c2p_req_type point;
      bit                   typed;
      c2p_pkg::c2p_rsp_type polar;
   } polar_vector_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   c2p_pkg::c2p_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   c2p_pkg::c2p_rsp_type rsp_data;

   c2p_pkg::c2p_rsp_type pending_polar [$];
   polar_vector_type     directed_vectors [$];
   int                   mismatch_count = 0;
   int                   burst_left = 0;

   cartesian_to_polar #(
      .STAGES(STAGES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // integer root for the magnitude, cordic vectoring for the angle
   function automatic c2p_pkg::c2p_rsp_type predict_polar(input c2p_pkg::c2p_req_type point);
      logic signed [c2p_pkg::CW-1:0]  px;
      logic signed [c2p_pkg::CW-1:0]  py;
      logic signed [c2p_pkg::CW-1:0]  dx;
      logic signed [c2p_pkg::CW-1:0]  dy;
      logic [63:0]                    ax;
      logic [63:0]                    ay;
      logic [63:0]                    rem;
      logic [63:0]                    root;
      logic [63:0]                    probe;
      logic [c2p_pkg::ACC_BITS-1:0]   acc;
      logic [c2p_pkg::ACC_BITS-1:0]   rounded;
      c2p_pkg::c2p_rsp_type           polar;
      px = $signed(point.x_coord);
      py = $signed(point.y_coord);
      ax = (px < 0) ? -px : px;
      ay = (py < 0) ? -py : py;

      // restoring square root, then round to nearest
      rem   = ax * ax + ay * ay;
      root  = 64'd0;
      probe = 64'd1 << 62;
      while (probe > rem)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      if (rem > root)
         root = root + 64'd1;
      polar.magnitude = root[c2p_pkg::COORD_BITS-1:0];

      // axis points get exact angles, others go through the rotator
      if (px == 0 && py == 0) begin
         polar.magnitude = '0;
         polar.angle     = ZERO_TURN;
         return polar;
      end else if (py == 0) begin
         acc = (px > 0) ? 32'h0000_0000 : 32'h8000_0000;
      end else if (px == 0) begin
         acc = (py > 0) ? 32'h4000_0000 : 32'hC000_0000;
      end else begin
         acc = 32'h0000_0000;
         if (px < 0) begin
            px  = -px;
            py  = -py;
            acc = 32'h8000_0000;
         end
         px = px <<< c2p_pkg::SCALE_SHIFT;
         py = py <<< c2p_pkg::SCALE_SHIFT;
         for (int i = 0; i < STAGES && i < 32; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (py > 0) begin
               px  = px + dx;
               py  = py - dy;
               acc = acc + c2p_pkg::ATAN_TURNS[i];
            end else begin
               px  = px - dx;
               py  = py + dy;
               acc = acc - c2p_pkg::ATAN_TURNS[i];
            end
         end
      end

      // round to the output resolution, a full turn wraps to zero
      rounded     = acc + (32'd1 << (31 - c2p_pkg::ANGLE_BITS));
      polar.angle = rounded[c2p_pkg::ACC_BITS-1 -: c2p_pkg::ANGLE_BITS];
      return polar;
   endfunction

   task automatic add_vector(input int x, input int y, input bit typed,
                             input int mag, input logic [c2p_pkg::ANGLE_BITS-1:0] ang);
      polar_vector_type vec;
      vec.point.x_coord   = x[c2p_pkg::COORD_BITS-1:0];
      vec.point.y_coord   = y[c2p_pkg::COORD_BITS-1:0];
      vec.typed           = typed;
      vec.polar.magnitude = mag[c2p_pkg::COORD_BITS-1:0];
      vec.polar.angle     = ang;
      directed_vectors.push_back(vec);
   endtask

   function automatic logic [c2p_pkg::COORD_BITS-1:0] pick_extreme();
      case ($urandom_range(0, 6))
         0: return 16'h8000;
         1: return 16'h8001;
         2: return 16'hFFFF;
         3: return 16'h0000;
         4: return 16'h0001;
         5: return 16'h7FFE;
         default: return 16'h7FFF;
      endcase
   endfunction

   // hold the item until accepted, then record its expected polar result
   task automatic send_point(input c2p_pkg::c2p_req_type point, input bit typed,
                             input c2p_pkg::c2p_rsp_type typed_polar);
      int gap;
      req_valid <= 1'b1;
      req_data  <= point;
      do
         @(posedge clock);
      while (!req_ready);
      pending_polar.push_back(typed ? typed_polar : predict_polar(point));

      // bursts of random length separated by random gaps
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 24);
      end
   endtask

   // stimulus and end of run
   initial begin
      c2p_pkg::c2p_req_type point;
      c2p_pkg::c2p_rsp_type no_polar;
      int                   step;
      no_polar  = '0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;

      // origin and axes, with exact expected values
      add_vector(0, 0, 1, 0, ZERO_TURN);
      add_vector(32767, 0, 1, 32767, ZERO_TURN);
      add_vector(-32768, 0, 1, 32768, HALF_TURN);
      add_vector(0, 32767, 1, 32767, QUARTER_TURN);
      add_vector(0, -32768, 1, 32768, THREE_QUARTER);
      add_vector(1, 0, 1, 1, ZERO_TURN);
      add_vector(-1, 0, 1, 1, HALF_TURN);
      add_vector(0, 1, 1, 1, QUARTER_TURN);
      add_vector(0, -1, 1, 1, THREE_QUARTER);
      // corners, all four quadrants, near-axis wrap cases
      add_vector(-32768, -32768, 0, 0, ZERO_TURN);
      add_vector(32767, 32767, 0, 0, ZERO_TURN);
      add_vector(-32768, 32767, 0, 0, ZERO_TURN);
      add_vector(32767, -32768, 0, 0, ZERO_TURN);
      add_vector(32767, -1, 0, 0, ZERO_TURN);
      add_vector(32767, 1, 0, 0, ZERO_TURN);
      add_vector(-32768, 1, 0, 0, ZERO_TURN);
      add_vector(-32768, -1, 0, 0, ZERO_TURN);
      add_vector(1, 1, 0, 0, ZERO_TURN);
      add_vector(-1, -1, 0, 0, ZERO_TURN);
      add_vector(1, -1, 0, 0, ZERO_TURN);
      add_vector(-1, 1, 0, 0, ZERO_TURN);
      add_vector(3, 4, 0, 0, ZERO_TURN);
      add_vector(1, -32768, 0, 0, ZERO_TURN);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 24);

      foreach (directed_vectors[k])
         send_point(directed_vectors[k].point, directed_vectors[k].typed,
                    directed_vectors[k].polar);

      // random points, half uniform, with small, near-axis, extreme and diagonal mixes
      for (step = 0; step < RANDOM_ITEMS; step++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               point.x_coord = CB'($urandom());
               point.y_coord = CB'($urandom());
            end
            5, 6: begin
               point.x_coord = CB'($urandom_range(0, 32) - 16);
               point.y_coord = CB'($urandom_range(0, 32) - 16);
            end
            7: begin
               if ($urandom_range(0, 1)) begin
                  point.x_coord = CB'($urandom());
                  point.y_coord = CB'($urandom_range(0, 4) - 2);
               end else begin
                  point.x_coord = CB'($urandom_range(0, 4) - 2);
                  point.y_coord = CB'($urandom());
               end
            end
            8: begin
               point.x_coord = pick_extreme();
               point.y_coord = pick_extreme();
            end
            default: begin
               point.x_coord = CB'($urandom());
               point.y_coord = $urandom_range(0, 1) ? point.x_coord : -point.x_coord;
            end
         endcase
         send_point(point, 1'b0, no_polar);
      end
      req_valid <= 1'b0;

      // drain, then allow for stray results
      while (pending_polar.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_polar.size() == 0) begin
         $display("tb_cartesian_to_polar: PASS");
      end else begin
         $display("tb_cartesian_to_polar: FAIL");
      end
      $finish;
   end

   // receiver ready, cycling through stall patterns
   initial begin
      int unsigned stall_cycle;
      rx_mode_type rx_mode;
      stall_cycle = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         stall_cycle++;
         rx_mode = rx_mode_type'((stall_cycle / 300) % 4);
         case (rx_mode)
            RX_ALWAYS:   rsp_ready <= 1'b1;
            RX_MOSTLY:   rsp_ready <= ($urandom_range(0, 9) < 7);
            RX_SELDOM:   rsp_ready <= ($urandom_range(0, 9) < 3);
            RX_PERIODIC: rsp_ready <= ((stall_cycle % 7) < 3);
            default:     rsp_ready <= 1'b1;
         endcase
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      c2p_pkg::c2p_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_polar.size() == 0) begin
            $error("unexpected result: magnitude %0d angle %0d",
                   rsp_data.magnitude, rsp_data.angle);
            mismatch_count++;
         end else begin
            want = pending_polar.pop_front();
            if (rsp_data.magnitude !== want.magnitude) begin
               $error("magnitude mismatch: expected %0d, actual %0d",
                      want.magnitude, rsp_data.magnitude);
               mismatch_count++;
            end
            if (rsp_data.angle !== want.angle) begin
               $error("angle mismatch: expected %0d, actual %0d",
                      want.angle, rsp_data.angle);
               mismatch_count++;
            end
         end
      end
   end

   // hard limit on run length
   initial begin
      #(TIMEOUT_NS);
      $display("tb_cartesian_to_polar: FAIL");
      $finish;
   end

endmodule

[files.f]
src/c2p_pkg.sv
src/cartesian_to_polar.sv
test/tb_cartesian_to_polar.sv
